// ----- rtl/core/des_bd_pkg.sv -----
package des_bd_pkg;

  localparam int ROUNDS    = 16;
  localparam int KEY_WORDS = 2 * ROUNDS;

  typedef logic [KEY_WORDS-1:0][31:0] subkeys_t;

  localparam logic [0:0] REG_CIPHER_KEY   = 1'b0;
  localparam logic [0:0] REG_ENCRYPT_MODE = 1'b1;

  localparam logic [63:0] KEY_RESET  = 64'h341C_849E_FDA4_B67B;
  localparam logic        MODE_RESET = 1'b0;

  localparam logic [31:0] MASK_NIBBLE = 32'hF0F0_F0F0;
  localparam logic [31:0] MASK_HALF   = 32'hFFFF_0000;
  localparam logic [31:0] MASK_PAIR   = 32'h3333_3333;
  localparam logic [31:0] MASK_BYTE   = 32'h00FF_00FF;
  localparam logic [31:0] MASK_BIT    = 32'hAAAA_AAAA;

  localparam logic [5:0] PC1 [56] = '{
    6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18,
    6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35, 6'd27, 6'd19, 6'd11, 6'd3,  6'd60, 6'd52, 6'd44, 6'd36,
    6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15, 6'd7,  6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22,
    6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21, 6'd13, 6'd5,  6'd28, 6'd20, 6'd12, 6'd4
  };

  localparam logic [4:0] SHIFT_TOTAL [16] = '{
    5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [5:0] PC2 [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [31:0] SPBOX [8][64] = '{
    '{32'h01010400, 32'h00000000, 32'h00010000, 32'h01010404, 32'h01010004, 32'h00010404,
      32'h00000004, 32'h00010000, 32'h00000400, 32'h01010400, 32'h01010404, 32'h00000400,
      32'h01000404, 32'h01010004, 32'h01000000, 32'h00000004, 32'h00000404, 32'h01000400,
      32'h01000400, 32'h00010400, 32'h00010400, 32'h01010000, 32'h01010000, 32'h01000404,
      32'h00010004, 32'h01000004, 32'h01000004, 32'h00010004, 32'h00000000, 32'h00000404,
      32'h00010404, 32'h01000000, 32'h00010000, 32'h01010404, 32'h00000004, 32'h01010000,
      32'h01010400, 32'h01000000, 32'h01000000, 32'h00000400, 32'h01010004, 32'h00010000,
      32'h00010400, 32'h01000004, 32'h00000400, 32'h00000004, 32'h01000404, 32'h00010404,
      32'h01010404, 32'h00010004, 32'h01010000, 32'h01000404, 32'h01000004, 32'h00000404,
      32'h00010404, 32'h01010400, 32'h00000404, 32'h01000400, 32'h01000400, 32'h00000000,
      32'h00010004, 32'h00010400, 32'h00000000, 32'h01010004},
    '{32'h80108020, 32'h80008000, 32'h00008000, 32'h00108020, 32'h00100000, 32'h00000020,
      32'h80100020, 32'h80008020, 32'h80000020, 32'h80108020, 32'h80108000, 32'h80000000,
      32'h80008000, 32'h00100000, 32'h00000020, 32'h80100020, 32'h00108000, 32'h00100020,
      32'h80008020, 32'h00000000, 32'h80000000, 32'h00008000, 32'h00108020, 32'h80100000,
      32'h00100020, 32'h80000020, 32'h00000000, 32'h00108000, 32'h00008020, 32'h80108000,
      32'h80100000, 32'h00008020, 32'h00000000, 32'h00108020, 32'h80100020, 32'h00100000,
      32'h80008020, 32'h80100000, 32'h80108000, 32'h00008000, 32'h80100000, 32'h80008000,
      32'h00000020, 32'h80108020, 32'h00108020, 32'h00000020, 32'h00008000, 32'h80000000,
      32'h00008020, 32'h80108000, 32'h00100000, 32'h80000020, 32'h00100020, 32'h80008020,
      32'h80000020, 32'h00100020, 32'h00108000, 32'h00000000, 32'h80008000, 32'h00008020,
      32'h80000000, 32'h80100020, 32'h80108020, 32'h00108000},
    '{32'h00000208, 32'h08020200, 32'h00000000, 32'h08020008, 32'h08000200, 32'h00000000,
      32'h00020208, 32'h08000200, 32'h00020008, 32'h08000008, 32'h08000008, 32'h00020000,
      32'h08020208, 32'h00020008, 32'h08020000, 32'h00000208, 32'h08000000, 32'h00000008,
      32'h08020200, 32'h00000200, 32'h00020200, 32'h08020000, 32'h08020008, 32'h00020208,
      32'h08000208, 32'h00020200, 32'h00020000, 32'h08000208, 32'h00000008, 32'h08020208,
      32'h00000200, 32'h08000000, 32'h08020200, 32'h08000000, 32'h00020008, 32'h00000208,
      32'h00020000, 32'h08020200, 32'h08000200, 32'h00000000, 32'h00000200, 32'h00020008,
      32'h08020208, 32'h08000200, 32'h08000008, 32'h00000200, 32'h00000000, 32'h08020008,
      32'h08000208, 32'h00020000, 32'h08000000, 32'h08020208, 32'h00000008, 32'h00020208,
      32'h00020200, 32'h08000008, 32'h08020000, 32'h08000208, 32'h00000208, 32'h08020000,
      32'h00020208, 32'h00000008, 32'h08020008, 32'h00020200},
    '{32'h00802001, 32'h00002081, 32'h00002081, 32'h00000080, 32'h00802080, 32'h00800081,
      32'h00800001, 32'h00002001, 32'h00000000, 32'h00802000, 32'h00802000, 32'h00802081,
      32'h00000081, 32'h00000000, 32'h00800080, 32'h00800001, 32'h00000001, 32'h00002000,
      32'h00800000, 32'h00802001, 32'h00000080, 32'h00800000, 32'h00002001, 32'h00002080,
      32'h00800081, 32'h00000001, 32'h00002080, 32'h00800080, 32'h00002000, 32'h00802080,
      32'h00802081, 32'h00000081, 32'h00800080, 32'h00800001, 32'h00802000, 32'h00802081,
      32'h00000081, 32'h00000000, 32'h00000000, 32'h00802000, 32'h00002080, 32'h00800080,
      32'h00800081, 32'h00000001, 32'h00802001, 32'h00002081, 32'h00002081, 32'h00000080,
      32'h00802081, 32'h00000081, 32'h00000001, 32'h00002000, 32'h00800001, 32'h00002001,
      32'h00802080, 32'h00800081, 32'h00002001, 32'h00002080, 32'h00800000, 32'h00802001,
      32'h00000080, 32'h00800000, 32'h00002000, 32'h00802080},
    '{32'h00000100, 32'h02080100, 32'h02080000, 32'h42000100, 32'h00080000, 32'h00000100,
      32'h40000000, 32'h02080000, 32'h40080100, 32'h00080000, 32'h02000100, 32'h40080100,
      32'h42000100, 32'h42080000, 32'h00080100, 32'h40000000, 32'h02000000, 32'h40080000,
      32'h40080000, 32'h00000000, 32'h40000100, 32'h42080100, 32'h42080100, 32'h02000100,
      32'h42080000, 32'h40000100, 32'h00000000, 32'h42000000, 32'h02080100, 32'h02000000,
      32'h42000000, 32'h00080100, 32'h00080000, 32'h42000100, 32'h00000100, 32'h02000000,
      32'h40000000, 32'h02080000, 32'h42000100, 32'h40080100, 32'h02000100, 32'h40000000,
      32'h42080000, 32'h02080100, 32'h40080100, 32'h00000100, 32'h02000000, 32'h42080000,
      32'h42080100, 32'h00080100, 32'h42000000, 32'h42080100, 32'h02080000, 32'h00000000,
      32'h40080000, 32'h42000000, 32'h00080100, 32'h02000100, 32'h40000100, 32'h00080000,
      32'h00000000, 32'h40080000, 32'h02080100, 32'h40000100},
    '{32'h20000010, 32'h20400000, 32'h00004000, 32'h20404010, 32'h20400000, 32'h00000010,
      32'h20404010, 32'h00400000, 32'h20004000, 32'h00404010, 32'h00400000, 32'h20000010,
      32'h00400010, 32'h20004000, 32'h20000000, 32'h00004010, 32'h00000000, 32'h00400010,
      32'h20004010, 32'h00004000, 32'h00404000, 32'h20004010, 32'h00000010, 32'h20400010,
      32'h20400010, 32'h00000000, 32'h00404010, 32'h20404000, 32'h00004010, 32'h00404000,
      32'h20404000, 32'h20000000, 32'h20004000, 32'h00000010, 32'h20400010, 32'h00404000,
      32'h20404010, 32'h00400000, 32'h00004010, 32'h20000010, 32'h00400000, 32'h20004000,
      32'h20000000, 32'h00004010, 32'h20000010, 32'h20404010, 32'h00404000, 32'h20400000,
      32'h00404010, 32'h20404000, 32'h00000000, 32'h20400010, 32'h00000010, 32'h00004000,
      32'h20400000, 32'h00404010, 32'h00004000, 32'h00400010, 32'h20004010, 32'h00000000,
      32'h20404000, 32'h20000000, 32'h00400010, 32'h20004010},
    '{32'h00200000, 32'h04200002, 32'h04000802, 32'h00000000, 32'h00000800, 32'h04000802,
      32'h00200802, 32'h04200800, 32'h04200802, 32'h00200000, 32'h00000000, 32'h04000002,
      32'h00000002, 32'h04000000, 32'h04200002, 32'h00000802, 32'h04000800, 32'h00200802,
      32'h00200002, 32'h04000800, 32'h04000002, 32'h04200000, 32'h04200800, 32'h00200002,
      32'h04200000, 32'h00000800, 32'h00000802, 32'h04200802, 32'h00200800, 32'h00000002,
      32'h04000000, 32'h00200800, 32'h04000000, 32'h00200800, 32'h00200000, 32'h04000802,
      32'h04000802, 32'h04200002, 32'h04200002, 32'h00000002, 32'h00200002, 32'h04000000,
      32'h04000800, 32'h00200000, 32'h04200800, 32'h00000802, 32'h00200802, 32'h04200800,
      32'h00000802, 32'h04000002, 32'h04200802, 32'h04200000, 32'h00200800, 32'h00000000,
      32'h00000002, 32'h04200802, 32'h00000000, 32'h00200802, 32'h04200000, 32'h00000800,
      32'h04000002, 32'h04000800, 32'h00000800, 32'h00200002},
    '{32'h10001040, 32'h00001000, 32'h00040000, 32'h10041040, 32'h10000000, 32'h10001040,
      32'h00000040, 32'h10000000, 32'h00040040, 32'h10040000, 32'h10041040, 32'h00041000,
      32'h10041000, 32'h00041040, 32'h00001000, 32'h00000040, 32'h10040000, 32'h10000040,
      32'h10001000, 32'h00001040, 32'h00041000, 32'h00040040, 32'h10040040, 32'h10041000,
      32'h00001040, 32'h00000000, 32'h00000000, 32'h10040040, 32'h10000040, 32'h10001000,
      32'h00041040, 32'h00040000, 32'h00041040, 32'h00040000, 32'h10041000, 32'h00001000,
      32'h00000040, 32'h10040040, 32'h00001000, 32'h00041040, 32'h10001000, 32'h00000040,
      32'h10000040, 32'h10040000, 32'h10040040, 32'h10000000, 32'h00040000, 32'h10001040,
      32'h00000000, 32'h10041040, 32'h00040040, 32'h10000040, 32'h10040000, 32'h10001000,
      32'h10001040, 32'h00000000, 32'h10041040, 32'h00041000, 32'h00041000, 32'h00001040,
      32'h00001040, 32'h00040040, 32'h10000000, 32'h10041000}
  };

  function automatic logic [31:0] rotl32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] bswap32(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic subkeys_t key_schedule(logic [63:0] key, logic mode);
    logic [55:0]      cd;
    logic [55:0]      rot;
    logic [7:0][5:0]  part;
    subkeys_t         fwd;
    subkeys_t         ks;
    int               p;
    for (int i = 0; i < 56; i++) begin
      cd[i] = key[64 - int'(PC1[i])];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      for (int j = 0; j < 56; j++) begin
        p = int'(SHIFT_TOTAL[r]) + j;
        if (j > 27) begin
          if (p > 55) p = p - 28;
        end else if (p > 27) begin
          p = p - 28;
        end
        rot[j] = cd[p];
      end
      for (int g = 0; g < 8; g++) begin
        for (int b = 0; b < 6; b++) begin
          part[g][5-b] = rot[int'(PC2[g*6+b]) - 1];
        end
      end
      fwd[2*r]   = {2'b00, part[0], 2'b00, part[2], 2'b00, part[4], 2'b00, part[6]};
      fwd[2*r+1] = {2'b00, part[1], 2'b00, part[3], 2'b00, part[5], 2'b00, part[7]};
    end
    for (int r = 0; r < ROUNDS; r++) begin
      if (mode) begin
        ks[2*r]   = fwd[2*r];
        ks[2*r+1] = fwd[2*r+1];
      end else begin
        ks[2*r]   = fwd[KEY_WORDS-2-2*r];
        ks[2*r+1] = fwd[KEY_WORDS-1-2*r];
      end
    end
    return ks;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, logic [31:0] k0, logic [31:0] k1);
    logic [31:0] a;
    logic [31:0] b;
    a = {r[3:0], r[31:4]} ^ k0;
    b = r ^ k1;
    return SPBOX[6][a[5:0]] ^ SPBOX[4][a[13:8]] ^ SPBOX[2][a[21:16]] ^ SPBOX[0][a[29:24]]
         ^ SPBOX[7][b[5:0]] ^ SPBOX[5][b[13:8]] ^ SPBOX[3][b[21:16]] ^ SPBOX[1][b[29:24]];
  endfunction

  function automatic logic [63:0] des_block(logic [31:0] first, logic [31:0] second,
                                            subkeys_t ks);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    l = bswap32(first);
    r = rotl32(bswap32(second), 4);
    t = (l ^ r) & MASK_NIBBLE; l = l ^ t; r = rotl32(r ^ t, 12);
    t = (l ^ r) & MASK_HALF;   l = l ^ t; r = rotl32(r ^ t, 14);
    t = (l ^ r) & MASK_PAIR;   l = l ^ t; r = rotl32(r ^ t, 26);
    t = (l ^ r) & MASK_BYTE;   l = l ^ t; r = rotl32(r ^ t, 9);
    t = (l ^ r) & MASK_BIT;    l = rotl32(l ^ t, 1); r = r ^ t;
    for (int k = 0; k < ROUNDS / 2; k++) begin
      l = l ^ feistel(r, ks[4*k],   ks[4*k+1]);
      r = r ^ feistel(l, ks[4*k+2], ks[4*k+3]);
    end
    r = rotl32(r, 31);
    t = (l ^ r) & MASK_BIT;    r = r ^ t; l = rotl32(l ^ t, 23);
    t = (l ^ r) & MASK_BYTE;   r = r ^ t; l = rotl32(l ^ t, 6);
    t = (l ^ r) & MASK_PAIR;   r = r ^ t; l = rotl32(l ^ t, 18);
    t = (l ^ r) & MASK_HALF;   r = r ^ t; l = rotl32(l ^ t, 20);
    t = (l ^ r) & MASK_NIBBLE; r = r ^ t; l = rotl32(l ^ t, 28);
    return {bswap32(r), bswap32(l)};
  endfunction

endpackage

// ----- rtl/core/des_block_decrypt_top.sv -----
// An input transfer is held in the input register; its result is offered from the result register.
// Throughput: one block per cycle; the input register and the result register
// let a new block enter every cycle while the result side is not stalled.
// The round path runs all sixteen rounds between the two registers.
// Reset (rst, synchronous): pipeline emptied, key and mode take their reset
// values, so the decrypt schedule of the reset key is in force at once.
module des_block_decrypt_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_first,
  output logic [31:0] result_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]          cipher_key;
  logic                 encrypt_mode;
  des_bd_pkg::subkeys_t round_subkeys;
  logic                 stage_valid;
  logic [31:0]          stage_first;
  logic [31:0]          stage_second;
  logic                 stage_advance;
  logic                 out_free;
  logic [63:0]          block_result;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || out_ready;
  assign stage_advance = stage_valid && out_free;
  assign in_ready      = !stage_valid || stage_advance;

  assign round_subkeys = des_bd_pkg::key_schedule(cipher_key, encrypt_mode);
  assign block_result  = des_bd_pkg::des_block(stage_first, stage_second, round_subkeys);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= des_bd_pkg::KEY_RESET;
      encrypt_mode <= des_bd_pkg::MODE_RESET;
      stage_valid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          des_bd_pkg::REG_CIPHER_KEY:   cipher_key   <= cfg_data;
          des_bd_pkg::REG_ENCRYPT_MODE: encrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_first  <= first_word;
      stage_second <= second_word;
    end
    if (stage_advance) begin
      result_first  <= block_result[63:32];
      result_second <= block_result[31:0];
    end
  end

endmodule
